// ----- hw/rtl/elevator_request_controller_assert.svh -----
// -----------------------------------------------------------------------------
// Elevator request controller assertion macros
// Concurrent assertion helpers for implication checks. They expand to nothing
// when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef ELEVATOR_REQUEST_CONTROLLER_ASSERT_SVH
`define ELEVATOR_REQUEST_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds.
`define ERC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication: cons must hold in the cycle after ante.
`define ERC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ERC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ERC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/erc_pkg.sv -----
// -----------------------------------------------------------------------------
// Elevator request controller package
// Shared constants, codes and types of the controller and the datapath.
// -----------------------------------------------------------------------------
package erc_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int FLOOR_COUNT = 8;

   localparam int TIME_W  = 48;
   localparam int FLOOR_W = 3;
   localparam int COUNT_W = 5;
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int HELD_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W = 2;

   localparam logic [TIME_W-1:0]  TIME_RESET = TIME_W'(5000000);
   localparam logic [FLOOR_W-1:0] TOP_FLOOR  = FLOOR_W'(FLOOR_COUNT - 1);
   localparam logic [PTR_W-1:0]   LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [HELD_W-1:0]  FULL_COUNT = HELD_W'(QUEUE_DEPTH);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOOR_TRAVEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOAD_DWELL   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNLOAD_DWELL = 2'd2;

   // Item kinds.
   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_TICK    = 2'd0,
      STATUS_QUEUED  = 2'd1,
      STATUS_DROPPED = 2'd2
   } status_type;

   // Car modes.
   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_MOVING    = 2'd1,
      MODE_LOADING   = 2'd2,
      MODE_UNLOADING = 2'd3
   } car_mode_type;

   // Travel direction, two-bit signed.
   localparam logic signed [1:0] DIR_NONE = 2'sb00;
   localparam logic signed [1:0] DIR_UP   = 2'sb01;
   localparam logic signed [1:0] DIR_DOWN = 2'sb11;

   typedef struct packed {
      logic [FLOOR_W-1:0] origin;
      logic [FLOOR_W-1:0] dest;
   } trip_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      CTRL_IDLE = 4'b0001,
      CTRL_READ = 4'b0010,
      CTRL_EXEC = 4'b0100,
      CTRL_DONE = 4'b1000
   } ctrl_state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic capture;
      logic read_head;
      logic execute;
      logic respond;
   } dp_cmd_type;

endpackage

// ----- hw/rtl/elevator_request_controller.sv -----
// -----------------------------------------------------------------------------
// Elevator request controller
// Single-car elevator controller with a request queue and a four-mode car
// machine driven by timestamped tick items.
// -----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low; busy
// then stays high while the head of the request queue is read from its memory
// (registered read) and the item is applied to the car state. Then rsp_valid
// is high for exactly one cycle with the result beat, and busy is already
// low, so the next item can be taken at the end of that cycle. The result
// beat cannot be stalled, so the receiver must take it in the cycle it is
// shown. Timing registers must be written through the csr port only while no
// item is in flight; the block itself does not enforce this.
// -----------------------------------------------------------------------------
`include "elevator_request_controller_assert.svh"

module elevator_request_controller
   import erc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   // Item channel: a tick (kind 0) or a travel request (kind 1).
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_kind,
   input  logic [TIME_W-1:0]      req_now_us,
   input  logic [FLOOR_W-1:0]     req_origin_floor,
   input  logic [FLOOR_W-1:0]     req_dest_floor,

   // Result channel: one beat per item.
   output logic                   rsp_valid,
   output logic [1:0]             rsp_request_status,
   output logic [FLOOR_W-1:0]     rsp_car_floor,
   output logic [1:0]             rsp_car_mode,
   output logic signed [1:0]      rsp_travel_dir,
   output logic                   rsp_target_valid,
   output logic [FLOOR_W-1:0]     rsp_target_floor,
   output logic [COUNT_W-1:0]     rsp_waiting_count,
   output logic                   rsp_floor_lamp_on,

   // Configuration write port.
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]      csr_write_data
);

   dp_cmd_type cmd;

   // The sequencer decides when the datapath captures, reads and executes.
   erc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath keeps all car, queue and timing state; its result
   // fields are held stable from the execute beat until the next item.
   erc_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_kind           (req_kind),
      .req_now_us         (req_now_us),
      .req_origin_floor   (req_origin_floor),
      .req_dest_floor     (req_dest_floor),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_request_status (rsp_request_status),
      .rsp_car_floor      (rsp_car_floor),
      .rsp_car_mode       (rsp_car_mode),
      .rsp_travel_dir     (rsp_travel_dir),
      .rsp_target_valid   (rsp_target_valid),
      .rsp_target_floor   (rsp_target_floor),
      .rsp_waiting_count  (rsp_waiting_count),
      .rsp_floor_lamp_on  (rsp_floor_lamp_on)
   );

   assign rsp_valid = cmd.respond;

   // An accepted item blocks further items in the following cycle.
   `ERC_ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy, busy, "accepted item did not raise busy")
   // Every accepted item yields its result beat after its read and execute states.
   `ERC_ASSERT_IMPLY(a_accept_to_result, clock, reset, start && !busy, ##3 rsp_valid, "result beat missing after accepted item")
   // The queue never reports more requests than it can hold.
   `ERC_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, rsp_waiting_count <= COUNT_W'(QUEUE_DEPTH), "waiting count beyond queue depth")
   // An idle car never carries an active target.
   `ERC_ASSERT_IMPLY(a_idle_no_target, clock, reset, rsp_valid && (rsp_car_mode == MODE_IDLE), !rsp_target_valid, "idle car reports an active target")

endmodule

// ----- hw/rtl/erc_ctrl.sv -----
// -----------------------------------------------------------------------------
// Elevator request controller sequencer
// Steps each accepted item through queue read, execute and result beats.
// -----------------------------------------------------------------------------
module erc_ctrl
   import erc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           accept;

   assign busy   = (state_ff == CTRL_READ) || (state_ff == CTRL_EXEC);
   assign accept = start && !busy;

   always_comb begin
      unique case (state_ff)
         CTRL_IDLE: state_in = accept ? CTRL_READ : CTRL_IDLE;
         CTRL_READ: state_in = CTRL_EXEC;
         CTRL_EXEC: state_in = CTRL_DONE;
         CTRL_DONE: state_in = accept ? CTRL_READ : CTRL_IDLE;
         default:   state_in = CTRL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.capture   = accept;
   assign cmd.read_head = (state_ff == CTRL_READ);
   assign cmd.execute   = (state_ff == CTRL_EXEC);
   assign cmd.respond   = (state_ff == CTRL_DONE);

endmodule

// ----- hw/rtl/erc_dpath.sv -----
// -----------------------------------------------------------------------------
// Elevator request controller datapath
// Holds the timing registers, the request queue and the car state, and
// applies one item per execute command.
// -----------------------------------------------------------------------------
module erc_dpath
   import erc_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   input  logic                          req_kind,
   input  logic [TIME_W-1:0]             req_now_us,
   input  logic [FLOOR_W-1:0]            req_origin_floor,
   input  logic [FLOOR_W-1:0]            req_dest_floor,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [TIME_W-1:0]             csr_write_data,
   output logic [1:0]                    rsp_request_status,
   output logic [FLOOR_W-1:0]            rsp_car_floor,
   output logic [1:0]                    rsp_car_mode,
   output logic signed [1:0]             rsp_travel_dir,
   output logic                          rsp_target_valid,
   output logic [FLOOR_W-1:0]            rsp_target_floor,
   output logic [COUNT_W-1:0]            rsp_waiting_count,
   output logic                          rsp_floor_lamp_on
);

   // Timing registers.
   logic [TIME_W-1:0] travel_ff, load_ff, unload_ff;

   // Captured item.
   logic               kind_ff;
   logic [TIME_W-1:0]  now_ff;
   trip_type           item_trip_ff;

   // Request queue.
   trip_type           queue_mem [QUEUE_DEPTH];
   trip_type           head_trip_ff;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic               queue_write;

   // Car state.
   car_mode_type       mode_ff, mode_in;
   logic [FLOOR_W-1:0] pos_ff, pos_in;
   logic signed [1:0]  dir_ff, dir_in;
   logic [FLOOR_W-1:0] goal_ff, goal_in;
   logic               goal_valid_ff, goal_valid_in;
   logic [FLOOR_W-1:0] riding_ff, riding_in;
   logic               started_ff, started_in;
   logic [TIME_W-1:0]  phase_time_ff, phase_time_in;
   status_type         status_ff, status_in;

   logic [TIME_W-1:0]  limit;
   logic [TIME_W-1:0]  elapsed;
   logic               timed_out;
   logic [FLOOR_W-1:0] stepped_pos;

   function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] f);
      return (f > TOP_FLOOR) ? TOP_FLOOR : f;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         travel_ff <= TIME_RESET;
         load_ff   <= TIME_RESET;
         unload_ff <= TIME_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_FLOOR_TRAVEL) begin
            travel_ff <= csr_write_data;
         end
         if (csr_index == CSR_LOAD_DWELL) begin
            load_ff <= csr_write_data;
         end
         if (csr_index == CSR_UNLOAD_DWELL) begin
            unload_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff             <= req_kind;
         now_ff              <= req_now_us;
         item_trip_ff.origin <= clamp_floor(req_origin_floor);
         item_trip_ff.dest   <= clamp_floor(req_dest_floor);
      end
   end

   // Queue memory: one write and one registered read.
   assign queue_write = cmd.execute && (kind_ff == KIND_REQUEST) && (held_ff != FULL_COUNT);

   always_ff @(posedge clock) begin
      if (queue_write) begin
         queue_mem[tail_ff] <= item_trip_ff;
      end
      if (cmd.read_head) begin
         head_trip_ff <= queue_mem[head_ff];
      end
   end

   always_comb begin
      unique case (mode_ff)
         MODE_MOVING:  limit = travel_ff;
         MODE_LOADING: limit = load_ff;
         default:      limit = unload_ff;
      endcase
   end

   assign elapsed   = now_ff - phase_time_ff;
   assign timed_out = (elapsed >= limit);

   always_comb begin
      stepped_pos = pos_ff;
      if (dir_ff > 2'sb00 && pos_ff < TOP_FLOOR) begin
         stepped_pos = pos_ff + FLOOR_W'(1);
      end else if (dir_ff < 2'sb00 && pos_ff > '0) begin
         stepped_pos = pos_ff - FLOOR_W'(1);
      end
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      held_in       = held_ff;
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      dir_in        = dir_ff;
      goal_in       = goal_ff;
      goal_valid_in = goal_valid_ff;
      riding_in     = riding_ff;
      started_in    = started_ff;
      phase_time_in = phase_time_ff;
      status_in     = STATUS_TICK;

      if (kind_ff == KIND_REQUEST) begin
         if (held_ff == FULL_COUNT) begin
            status_in = STATUS_DROPPED;
         end else begin
            status_in = STATUS_QUEUED;
            tail_in   = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PTR_W'(1);
            held_in   = held_ff + HELD_W'(1);
         end
      end else begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (held_ff != '0) begin
                  head_in       = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_W'(1);
                  held_in       = held_ff - HELD_W'(1);
                  riding_in     = head_trip_ff.dest;
                  goal_in       = head_trip_ff.origin;
                  goal_valid_in = 1'b1;
                  phase_time_in = now_ff;
                  if (pos_ff == head_trip_ff.origin) begin
                     mode_in = MODE_LOADING;
                  end else begin
                     dir_in  = (head_trip_ff.origin > pos_ff) ? DIR_UP : DIR_DOWN;
                     mode_in = MODE_MOVING;
                  end
               end
            end
            MODE_MOVING: begin
               if (!started_ff) begin
                  started_in = 1'b1;
               end else if (timed_out) begin
                  pos_in        = stepped_pos;
                  phase_time_in = now_ff;
                  if (stepped_pos == goal_ff) begin
                     started_in = 1'b0;
                     mode_in    = MODE_LOADING;
                  end
               end
            end
            MODE_LOADING: begin
               if (!started_ff) begin
                  started_in    = 1'b1;
                  phase_time_in = now_ff;
               end else if (timed_out) begin
                  started_in    = 1'b0;
                  goal_in       = riding_ff;
                  phase_time_in = now_ff;
                  if (riding_ff > pos_ff) begin
                     dir_in = DIR_UP;
                  end else if (riding_ff < pos_ff) begin
                     dir_in = DIR_DOWN;
                  end
                  mode_in = (riding_ff == pos_ff) ? MODE_UNLOADING : MODE_MOVING;
               end
            end
            default: begin
               if (!started_ff) begin
                  started_in    = 1'b1;
                  phase_time_in = now_ff;
               end else if (timed_out) begin
                  started_in    = 1'b0;
                  goal_valid_in = 1'b0;
                  mode_in       = MODE_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         held_ff       <= '0;
         mode_ff       <= MODE_IDLE;
         pos_ff        <= '0;
         dir_ff        <= DIR_NONE;
         goal_ff       <= '0;
         goal_valid_ff <= 1'b0;
         riding_ff     <= '0;
         started_ff    <= 1'b0;
         phase_time_ff <= '0;
         status_ff     <= STATUS_TICK;
      end else if (cmd.execute) begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         held_ff       <= held_in;
         mode_ff       <= mode_in;
         pos_ff        <= pos_in;
         dir_ff        <= dir_in;
         goal_ff       <= goal_in;
         goal_valid_ff <= goal_valid_in;
         riding_ff     <= riding_in;
         started_ff    <= started_in;
         phase_time_ff <= phase_time_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_request_status = status_ff;
   assign rsp_car_floor      = pos_ff;
   assign rsp_car_mode       = mode_ff;
   assign rsp_travel_dir     = dir_ff;
   assign rsp_target_valid   = goal_valid_ff;
   assign rsp_target_floor   = goal_valid_ff ? goal_ff : '0;
   assign rsp_waiting_count  = COUNT_W'(held_ff);
   assign rsp_floor_lamp_on  = !((mode_ff == MODE_MOVING) && started_ff);

endmodule

// ----- sim/elevator_request_controller_checker.sv -----
// -----------------------------------------------------------------------------
// Elevator request controller checker
// Watches the item, result and timing-register ports, keeps its own model of
// the car and the request queue, and compares every result beat against it.
// -----------------------------------------------------------------------------
module elevator_request_controller_checker
   import erc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic                   req_kind,
   input  logic [TIME_W-1:0]      req_now_us,
   input  logic [FLOOR_W-1:0]     req_origin_floor,
   input  logic [FLOOR_W-1:0]     req_dest_floor,
   input  logic                   rsp_valid,
   input  logic [1:0]             rsp_request_status,
   input  logic [FLOOR_W-1:0]     rsp_car_floor,
   input  logic [1:0]             rsp_car_mode,
   input  logic signed [1:0]      rsp_travel_dir,
   input  logic                   rsp_target_valid,
   input  logic [FLOOR_W-1:0]     rsp_target_floor,
   input  logic [COUNT_W-1:0]     rsp_waiting_count,
   input  logic                   rsp_floor_lamp_on,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]      csr_write_data,
   input  logic                   end_of_test,
   output int                     outstanding,
   output int                     beats_checked,
   output int                     drops_seen,
   output int                     mismatch_count
);

   typedef struct packed {
      status_type         status;
      logic [FLOOR_W-1:0] floor_now;
      car_mode_type       mode;
      logic [1:0]         dir;
      logic               aim_valid;
      logic [FLOOR_W-1:0] aim_floor;
      logic [COUNT_W-1:0] waiting;
      logic               lamp;
   } car_report_t;

   logic [TIME_W-1:0]  travel_us;
   logic [TIME_W-1:0]  load_us;
   logic [TIME_W-1:0]  unload_us;

   logic [FLOOR_W-1:0] car_at;
   car_mode_type       mode_now;
   logic [1:0]         dir_now;
   logic [FLOOR_W-1:0] aim;
   logic               aim_on;
   logic [FLOOR_W-1:0] rider_dest;
   logic               phase_on;
   logic [TIME_W-1:0]  phase_t0;
   trip_type           trips [QUEUE_DEPTH];
   logic [PTR_W-1:0]   rd_ptr;
   logic [PTR_W-1:0]   wr_ptr;
   logic [HELD_W-1:0]  held;

   car_report_t        awaited [$];
   bit                 closed;

   function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] f);
      return (f > TOP_FLOOR) ? TOP_FLOOR : f;
   endfunction

   // Elapsed time is taken modulo 2^48, so a timestamp wrap is harmless.
   function automatic logic expired(input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] limit);
      logic [TIME_W-1:0] elapsed;
      elapsed = now - phase_t0;
      return elapsed >= limit;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("MISMATCH at beat %0d: %s got %0d, want %0d", beats_checked, what,
                  got, want);
   endtask

   // Applies one item to the car model and returns the report it should produce.
   task automatic advance_car(input logic kind, input logic [TIME_W-1:0] now,
                              input logic [FLOOR_W-1:0] origin,
                              input logic [FLOOR_W-1:0] dest,
                              output car_report_t r);
      status_type st;
      trip_type   t;
      st = STATUS_TICK;
      if (kind == KIND_REQUEST) begin
         if (held >= FULL_COUNT) begin
            st = STATUS_DROPPED;
         end else begin
            trips[wr_ptr] = '{origin: clamp_floor(origin), dest: clamp_floor(dest)};
            wr_ptr = wr_ptr + 1'b1;
            held = held + 1'b1;
            st = STATUS_QUEUED;
         end
      end else begin
         case (mode_now)
            MODE_IDLE: begin
               if (held != 0) begin
                  t = trips[rd_ptr];
                  rd_ptr = rd_ptr + 1'b1;
                  held = held - 1'b1;
                  rider_dest = t.dest;
                  aim = t.origin;
                  aim_on = 1'b1;
                  phase_t0 = now;
                  if (car_at == aim) begin
                     mode_now = MODE_LOADING;
                  end else begin
                     dir_now = (aim > car_at) ? DIR_UP : DIR_DOWN;
                     mode_now = MODE_MOVING;
                  end
               end
            end
            MODE_MOVING: begin
               if (!phase_on) begin
                  phase_on = 1'b1;
               end else if (expired(now, travel_us)) begin
                  if (dir_now == DIR_UP && car_at < TOP_FLOOR)
                     car_at = car_at + 1'b1;
                  else if (dir_now == DIR_DOWN && car_at > 0)
                     car_at = car_at - 1'b1;
                  phase_t0 = now;
                  if (car_at == aim) begin
                     phase_on = 1'b0;
                     mode_now = MODE_LOADING;
                  end
               end
            end
            MODE_LOADING: begin
               if (!phase_on) begin
                  phase_on = 1'b1;
                  phase_t0 = now;
               end else if (expired(now, load_us)) begin
                  phase_on = 1'b0;
                  aim = rider_dest;
                  if (aim > car_at)
                     dir_now = DIR_UP;
                  else if (aim < car_at)
                     dir_now = DIR_DOWN;
                  phase_t0 = now;
                  if (aim == car_at)
                     mode_now = MODE_UNLOADING;
                  else
                     mode_now = MODE_MOVING;
               end
            end
            default: begin
               if (!phase_on) begin
                  phase_on = 1'b1;
                  phase_t0 = now;
               end else if (expired(now, unload_us)) begin
                  phase_on = 1'b0;
                  aim_on = 1'b0;
                  mode_now = MODE_IDLE;
               end
            end
         endcase
      end
      r.status    = st;
      r.floor_now = car_at;
      r.mode      = mode_now;
      r.dir       = dir_now;
      r.aim_valid = aim_on;
      r.aim_floor = aim_on ? aim : '0;
      r.waiting   = COUNT_W'(held);
      r.lamp      = !(mode_now == MODE_MOVING && phase_on);
   endtask

   always @(posedge clock) begin
      car_report_t w;
      car_report_t fresh;
      if (reset) begin
         travel_us  = TIME_RESET;
         load_us    = TIME_RESET;
         unload_us  = TIME_RESET;
         car_at     = '0;
         mode_now   = MODE_IDLE;
         dir_now    = DIR_NONE;
         aim        = '0;
         aim_on     = 1'b0;
         rider_dest = '0;
         phase_on   = 1'b0;
         phase_t0   = '0;
         rd_ptr     = '0;
         wr_ptr     = '0;
         held       = '0;
         closed     = 1'b0;
         awaited.delete();
      end else begin
         // The result beat is compared before a new item is queued, since the
         // next item can be taken at the same edge that ends a result beat.
         if (rsp_valid) begin
            if (awaited.size() == 0) begin
               report_mismatch("result beat with nothing pending", 1, 0);
            end else begin
               w = awaited.pop_front();
               if (rsp_request_status !== w.status)
                  report_mismatch("request_status", rsp_request_status, w.status);
               if (rsp_car_floor !== w.floor_now)
                  report_mismatch("car_floor", rsp_car_floor, w.floor_now);
               if (rsp_car_mode !== w.mode)
                  report_mismatch("car_mode", rsp_car_mode, w.mode);
               if (rsp_travel_dir !== w.dir)
                  report_mismatch("travel_dir", rsp_travel_dir, $signed(w.dir));
               if (rsp_target_valid !== w.aim_valid)
                  report_mismatch("target_valid", rsp_target_valid, w.aim_valid);
               if (rsp_target_floor !== w.aim_floor)
                  report_mismatch("target_floor", rsp_target_floor, w.aim_floor);
               if (rsp_waiting_count !== w.waiting)
                  report_mismatch("waiting_count", rsp_waiting_count, w.waiting);
               if (rsp_floor_lamp_on !== w.lamp)
                  report_mismatch("floor_lamp_on", rsp_floor_lamp_on, w.lamp);
            end
            beats_checked++;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FLOOR_TRAVEL: travel_us = csr_write_data;
               CSR_LOAD_DWELL:   load_us   = csr_write_data;
               CSR_UNLOAD_DWELL: unload_us = csr_write_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            advance_car(req_kind, req_now_us, req_origin_floor, req_dest_floor, fresh);
            if (fresh.status == STATUS_DROPPED)
               drops_seen++;
            awaited.push_back(fresh);
         end
         if (end_of_test && !closed) begin
            closed = 1'b1;
            if (awaited.size() != 0)
               report_mismatch("result beats never returned", awaited.size(), 0);
         end
      end
      outstanding <= awaited.size();
   end

endmodule

// ----- sim/elevator_request_controller_test.sv -----
// -----------------------------------------------------------------------------
// Elevator request controller testbench
// Drives tick and travel-request items into the controller, reprograms the
// three timing registers between phases and leaves all prediction and checking
// to the checker module, which reports its mismatch count for the verdict.
// -----------------------------------------------------------------------------
module elevator_request_controller_test;
   import erc_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int WATCHDOG_LIMIT = 2000;
   // A result beat shows up once its item has passed the read and execute states;
   // the hold-off after draining is well beyond that.
   localparam int SETTLE_CYCLES  = 8;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_kind = KIND_TICK;
   logic [TIME_W-1:0]      req_now_us = '0;
   logic [FLOOR_W-1:0]     req_origin_floor = '0;
   logic [FLOOR_W-1:0]     req_dest_floor = '0;
   logic                   rsp_valid;
   logic [1:0]             rsp_request_status;
   logic [FLOOR_W-1:0]     rsp_car_floor;
   logic [1:0]             rsp_car_mode;
   logic signed [1:0]      rsp_travel_dir;
   logic                   rsp_target_valid;
   logic [FLOOR_W-1:0]     rsp_target_floor;
   logic [COUNT_W-1:0]     rsp_waiting_count;
   logic                   rsp_floor_lamp_on;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FLOOR_TRAVEL;
   logic [TIME_W-1:0]      csr_write_data = '0;

   logic                   end_of_test = 1'b0;
   int                     outstanding;
   int                     beats_checked;
   int                     drops_seen;
   int                     mismatch_count;

   // The microsecond clock that tick items carry. It wraps at 2^48 on its own.
   logic [TIME_W-1:0]      wall_us = '0;
   // Shadow copies of the timing registers, used to aim tick spacing at the
   // points where a phase just completes or just misses.
   logic [TIME_W-1:0]      travel_us = TIME_RESET;
   logic [TIME_W-1:0]      load_us = TIME_RESET;
   logic [TIME_W-1:0]      unload_us = TIME_RESET;
   // Chance, in percent, that the sender inserts an idle burst before a beat.
   int                     gap_pct = 0;
   int                     trips_sent = 0;
   int                     ticks_sent = 0;
   int                     settings_used = 1;
   int                     idle_cycles = 0;

   always #HALF_PERIOD clock = ~clock;

   elevator_request_controller uut (.*);

   elevator_request_controller_checker u_checker (.*);

   // Sends one item beat and returns at the edge that accepts it. Start is left
   // high on return so that back-to-back beats never lower and raise it within
   // one time step; every path that lets time pass lowers it first.
   task automatic send_beat(input logic kind, input logic [TIME_W-1:0] now,
                            input logic [FLOOR_W-1:0] origin,
                            input logic [FLOOR_W-1:0] dest);
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_now_us       <= now;
      req_origin_floor <= origin;
      req_dest_floor   <= dest;
      do @(posedge clock); while (busy);
   endtask

   // A tick moves the microsecond clock forward by the given step. The floor
   // fields are ignored on ticks, so they carry random noise.
   task automatic send_tick(input logic [TIME_W-1:0] step);
      wall_us = wall_us + step;
      ticks_sent++;
      send_beat(KIND_TICK, wall_us, FLOOR_W'($urandom_range(0, 7)),
                FLOOR_W'($urandom_range(0, 7)));
   endtask

   // A travel request; its timestamp field is ignored, so it is random.
   task automatic send_trip(input logic [FLOOR_W-1:0] origin,
                            input logic [FLOOR_W-1:0] dest);
      trips_sent++;
      send_beat(KIND_REQUEST, TIME_W'({$urandom, $urandom}), origin, dest);
   endtask

   // Picks the spacing of the next tick. Most steps sit on or right around one
   // of the programmed durations, so phases complete often and the boundary
   // compare is hit from both sides; others are zero, small, halved, huge or random.
   function automatic logic [TIME_W-1:0] next_step();
      logic [TIME_W-1:0] span;
      case ($urandom_range(0, 2))
         0:       span = travel_us;
         1:       span = load_us;
         default: span = unload_us;
      endcase
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return span - 1'b1;
         2, 3, 4: return span;
         5:       return span + 1'b1;
         6, 7:    return span + TIME_W'($urandom_range(0, 64));
         8:       return TIME_W'($urandom_range(0, 15));
         9:       return TIME_W'({$urandom, $urandom});
         10:      return TIME_MAX;
         default: return span >> 1;
      endcase
   endfunction

   // A stretch of random traffic: trip_pct percent travel requests with random
   // floors, the rest ticks spaced by next_step.
   task automatic run_traffic(input int beats, input int trip_pct);
      repeat (beats) begin
         if ($urandom_range(0, 99) < trip_pct)
            send_trip(FLOOR_W'($urandom_range(0, 7)), FLOOR_W'($urandom_range(0, 7)));
         else
            send_tick(next_step());
      end
   endtask

   // Holds the sender off until every expected result beat has arrived, then
   // lets a few more cycles pass so the block is quiet.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three timing registers, one per cycle, while nothing is in
   // flight, and updates the shadow copies.
   task automatic program_timing(input logic [TIME_W-1:0] travel,
                                 input logic [TIME_W-1:0] load,
                                 input logic [TIME_W-1:0] unload);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FLOOR_TRAVEL;
      csr_write_data   <= travel;
      @(posedge clock);
      csr_index        <= CSR_LOAD_DWELL;
      csr_write_data   <= load;
      @(posedge clock);
      csr_index        <= CSR_UNLOAD_DWELL;
      csr_write_data   <= unload;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      travel_us = travel;
      load_us   = load;
      unload_us = unload;
      settings_used++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening, with the timing registers at their reset values.
      // The clock starts at its top value and wraps to zero before the first
      // phase. A tick on an idle car with an empty queue changes nothing.
      wall_us = TIME_MAX;
      send_tick('0);
      // Extreme floors both ways, then a trip whose destination is its pickup.
      send_trip(3'd0, 3'd7);
      send_trip(3'd7, 3'd0);
      send_trip(3'd3, 3'd3);
      // This tick wraps the clock to zero and takes the first trip. The pickup
      // is the current floor, so the car goes straight to loading.
      send_tick(TIME_W'(1));
      // First loading tick only marks the start; then one microsecond short of
      // the dwell, then exactly on it, and the car leaves for the top floor.
      send_tick('0);
      send_tick(TIME_RESET - 1'b1);
      send_tick(TIME_W'(1));
      // First moving tick marks the phase and turns the lamp off; seven full
      // travel times carry the car to the top floor.
      send_tick('0);
      repeat (7) send_tick(TIME_RESET);
      // Loading again at the destination goes straight on to unloading, and
      // the end of unloading drops back to idle with the target cleared.
      send_tick('0);
      send_tick(TIME_RESET);
      send_tick('0);
      send_tick(TIME_RESET);
      // The next trip is only taken on the following tick; its pickup is the
      // floor the car stands on.
      send_tick(TIME_RESET);

      // Short durations so that trips complete often, with idle bursts.
      settle();
      program_timing(TIME_W'($urandom_range(1, 50)), TIME_W'($urandom_range(1, 50)),
                     TIME_W'($urandom_range(1, 50)));
      gap_pct = 30;
      run_traffic(140, 25);
      // A flood of requests with no gaps fills the queue until requests are
      // dropped, then mostly ticks to empty it again.
      gap_pct = 0;
      run_traffic(40, 85);
      gap_pct = 50;
      run_traffic(60, 5);

      // Durations of one microsecond each.
      settle();
      program_timing(TIME_W'(1), TIME_W'(1), TIME_W'(1));
      gap_pct = 20;
      run_traffic(60, 35);

      // Largest durations: a phase only completes on an exact full-range step,
      // so the car mostly sits while the queue fills up.
      settle();
      program_timing(TIME_MAX, TIME_MAX, TIME_MAX);
      run_traffic(30, 40);

      // Zero durations: every tick after the first of a phase completes it.
      settle();
      program_timing('0, '0, '0);
      run_traffic(40, 30);

      // A huge random travel time against short dwells.
      settle();
      program_timing(TIME_W'({$urandom, $urandom}), TIME_W'($urandom_range(1, 100)),
                     TIME_W'($urandom_range(1, 100)));
      run_traffic(60, 30);

      // Final stretch at full rate with no idling at all.
      settle();
      program_timing(TIME_W'($urandom_range(1, 1000)), TIME_W'($urandom_range(1, 1000)),
                     TIME_W'($urandom_range(1, 1000)));
      gap_pct = 0;
      run_traffic(100, 30);

      settle();
      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      $display("Summary: %0d items (%0d travel requests, %0d ticks) over %0d timing settings.",
               trips_sent + ticks_sent, trips_sent, ticks_sent, settings_used);
      $display("Summary: %0d result beats checked, %0d requests dropped on a full queue.",
               beats_checked, drops_seen);
      if (mismatch_count == 0)
         $display("elevator_request_controller_test passed");
      else
         $display("elevator_request_controller_test failed");
      $finish;
   end

   // Watchdog: counts cycles in which no item is taken, no result beat shows
   // up and no register is written, and stops a run that has hung.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles, %0d results outstanding.",
                  idle_cycles, outstanding);
         $display("elevator_request_controller_test failed");
         $finish;
      end
   end

endmodule
